>>> hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// shared word width, counter width and transfer payload types for the
// modular exponentiation block
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

    typedef struct packed {
        logic [WORD_BITS-1:0] base_value;
        logic [WORD_BITS-1:0] exponent;
    } in_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] power_result;
        logic                 modulus_error;
    } out_item_t;

endpackage

`default_nettype wire

>>> hdl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// shared shift-add modular multiplier, one multiplier bit per cycle,
// product = x * y mod m for x < m
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_mulmod (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mexp_pkg::WORD_BITS-1:0] op_x,
    input  wire logic [mexp_pkg::WORD_BITS-1:0] op_y,
    input  wire logic [mexp_pkg::WORD_BITS-1:0] modulus,
    output logic                               done,
    output logic [mexp_pkg::WORD_BITS-1:0]     product
);
    import mexp_pkg::*;

    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] x_reg;
    logic [WORD_BITS-1:0] y_reg;
    logic [WORD_BITS-1:0] m_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [WORD_BITS+1:0] sum;
    logic [WORD_BITS+2:0] diff_one;
    logic [WORD_BITS+2:0] diff_two;

    // 2*acc + bit*x lies below 3m, so subtract m or 2m at most
    always_comb
    begin
        sum      = {1'b0, acc_reg, 1'b0} + (y_reg[WORD_BITS-1] ? {2'b00, x_reg} : '0);
        diff_one = {1'b0, sum} - {3'b000, m_reg};
        diff_two = {1'b0, sum} - {2'b00, m_reg, 1'b0};
        if (!diff_two[WORD_BITS+2])
        begin
            acc_next = diff_two[WORD_BITS-1:0];
        end
        else if (!diff_one[WORD_BITS+2])
        begin
            acc_next = diff_one[WORD_BITS-1:0];
        end
        else
        begin
            acc_next = sum[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(WORD_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and accumulator registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            x_reg   <= op_x;
            y_reg   <= op_y;
            m_reg   <= modulus;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[WORD_BITS-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

>>> hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base_value ^ exponent mod modulus by left-to-right square-and-multiply over
// one shared shift-add modular multiplier
// ----------------------------------------------------------------------------
// sequencing: a zero exponent or zero modulus goes straight to the output
//   state; otherwise the base is reduced, then every exponent bit takes a square
//   and each one bit also a multiply on the shared modular multiplier
// throughput: one item at a time, the input is stalled until the result is
//   loaded into the output register; a stalled output holds the sequencer
// reset: asynchronous active low, modulus returns to 1, no transfer pending
`default_nettype none

module modular_exponentiation (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration: modulus register
    input  wire logic                          cfg_we,
    input  wire logic [mexp_pkg::WORD_BITS-1:0] cfg_data,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire mexp_pkg::in_item_t            in_data,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output mexp_pkg::out_item_t                out_data
);
    import mexp_pkg::*;

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;  // waiting for an input transfer
    localparam logic [2:0] ST_REDUCE = 3'd1;  // base reduced modulo the modulus
    localparam logic [2:0] ST_SQUARE = 3'd2;  // acc = acc * acc mod m
    localparam logic [2:0] ST_MULT   = 3'd3;  // acc = acc * base mod m
    localparam logic [2:0] ST_OUT    = 3'd4;  // result waits for the output register

    logic [2:0]           state_reg;
    logic [WORD_BITS-1:0] modulus_reg;
    logic [WORD_BITS-1:0] acc_reg;        // running power, also 1 mod m at start
    logic [WORD_BITS-1:0] base_reg;       // raw base, then base mod m
    logic [WORD_BITS-1:0] expo_reg;       // exponent, scanned from the top bit
    logic [CNT_BITS-1:0]  bit_cnt_reg;    // exponent bits still to scan
    logic                 start_reg;      // kicks the multiplier
    logic                 res_err_reg;
    logic                 out_valid_reg;
    out_item_t            out_data_reg;

    logic                 in_xfer;
    logic                 out_free;
    logic                 mm_done;
    logic [WORD_BITS-1:0] mm_product;
    logic [WORD_BITS-1:0] mm_x;
    logic [WORD_BITS-1:0] mm_y;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // operand selection for the shared multiplier
    // reduction: (1 mod m) times the base bit-serially gives base mod m
    always_comb
    begin
        case (state_reg)
            ST_REDUCE:
            begin
                mm_x = acc_reg;
                mm_y = base_reg;
            end
            ST_MULT:
            begin
                mm_x = acc_reg;
                mm_y = base_reg;
            end
            default:
            begin
                mm_x = acc_reg;
                mm_y = acc_reg;
            end
        endcase
    end

    mexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .op_x    (mm_x),
        .op_y    (mm_y),
        .modulus (modulus_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= WORD_BITS'(1);
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_data;
        end
    end

    // sequencer and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            // a new result replaces a collected one in the same cycle
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if ((in_data.exponent == '0) || (modulus_reg == '0))
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            state_reg   <= ST_REDUCE;
                            start_reg   <= 1'b1;
                            bit_cnt_reg <= CNT_BITS'(WORD_BITS);
                        end
                    end
                end
                ST_REDUCE:
                begin
                    if (mm_done)
                    begin
                        state_reg <= ST_SQUARE;
                        start_reg <= 1'b1;
                    end
                end
                ST_SQUARE:
                begin
                    if (mm_done)
                    begin
                        if (expo_reg[WORD_BITS-1])
                        begin
                            state_reg <= ST_MULT;
                            start_reg <= 1'b1;
                        end
                        else if (bit_cnt_reg == CNT_BITS'(1))
                        begin
                            state_reg   <= ST_OUT;
                            bit_cnt_reg <= '0;
                        end
                        else
                        begin
                            start_reg   <= 1'b1;
                            bit_cnt_reg <= bit_cnt_reg - 1'b1;
                        end
                    end
                end
                ST_MULT:
                begin
                    if (mm_done)
                    begin
                        if (bit_cnt_reg == CNT_BITS'(1))
                        begin
                            state_reg   <= ST_OUT;
                            bit_cnt_reg <= '0;
                        end
                        else
                        begin
                            state_reg   <= ST_SQUARE;
                            start_reg   <= 1'b1;
                            bit_cnt_reg <= bit_cnt_reg - 1'b1;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    base_reg <= in_data.base_value;
                    expo_reg <= in_data.exponent;
                    // zero exponent gives 1, zero modulus gives 0 with error
                    if (in_data.exponent == '0)
                    begin
                        acc_reg     <= WORD_BITS'(1);
                        res_err_reg <= 1'b0;
                    end
                    else if (modulus_reg == '0)
                    begin
                        acc_reg     <= '0;
                        res_err_reg <= 1'b1;
                    end
                    else
                    begin
                        // 1 mod m, zero for a modulus of one
                        acc_reg     <= (modulus_reg == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
                        res_err_reg <= 1'b0;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mm_done)
                begin
                    base_reg <= mm_product;
                end
            end
            ST_SQUARE:
            begin
                if (mm_done)
                begin
                    acc_reg <= mm_product;
                    if (!expo_reg[WORD_BITS-1])
                    begin
                        expo_reg <= {expo_reg[WORD_BITS-2:0], 1'b0};
                    end
                end
            end
            ST_MULT:
            begin
                if (mm_done)
                begin
                    acc_reg  <= mm_product;
                    expo_reg <= {expo_reg[WORD_BITS-2:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register, loaded when the sequencer hands over a result
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_data_reg.power_result  <= acc_reg;
            out_data_reg.modulus_error <= res_err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for modular_exponentiation: a short table of directed
// operands, then random phases each under a freshly written modulus, with
// every output transfer compared against a typed value or a square-and-multiply predictor
// ----------------------------------------------------------------------------

module tb_top;

    import mexp_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLES    = 50;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 27;
    localparam int DIRECTED_ROWS   = 25;

    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

    // one directed operation: modulus in force, operands, and where the answer
    // is obvious the typed expectation (otherwise the predictor supplies it)
    typedef struct {
        logic [WORD_BITS-1:0] modulus;
        logic [WORD_BITS-1:0] base;
        logic [WORD_BITS-1:0] expo;
        bit                   typed;
        logic [WORD_BITS-1:0] power;
        bit                   err;
    } dir_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [WORD_BITS-1:0] cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;

    // mirror of the modulus register, reset value 1
    logic [WORD_BITS-1:0] modulus_now = 1;

    out_item_t pending_powers[$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    int        stall_left     = 0;
    bit        idling_on      = 1'b1;

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        // reset modulus of one
        '{32'd1,        32'd5,        32'd0,        1'b1, 32'd1,        1'b0},
        '{32'd1,        32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0,        1'b0},
        // zero modulus: zero exponent still gives one, otherwise error
        '{32'd0,        32'd7,        32'd0,        1'b1, 32'd1,        1'b0},
        '{32'd0,        32'd7,        32'd3,        1'b1, 32'd0,        1'b1},
        '{32'd0,        32'hFFFFFFFF, 32'd1,        1'b1, 32'd0,        1'b1},
        '{32'd0,        32'd0,        32'h80000000, 1'b1, 32'd0,        1'b1},
        // largest modulus, base at or just below it and some small bases
        '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'd5,        1'b1, 32'd0,        1'b0},
        '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'd2,        1'b1, 32'd1,        1'b0},
        '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFE, 1'b0},
        '{32'hFFFFFFFF, 32'd2,        32'd31,       1'b1, 32'h80000000, 1'b0},
        '{32'hFFFFFFFF, 32'd2,        32'd32,       1'b1, 32'd1,        1'b0},
        '{32'hFFFFFFFF, 32'd0,        32'hFFFFFFFF, 1'b1, 32'd0,        1'b0},
        '{32'hFFFFFFFF, 32'd1,        32'hFFFFFFFF, 1'b1, 32'd1,        1'b0},
        '{32'hFFFFFFFF, 32'h12345678, 32'd0,        1'b1, 32'd1,        1'b0},
        // largest 32-bit prime: fermat's little theorem, and base reduction
        '{32'hFFFFFFFB, 32'h9E3779B9, 32'hFFFFFFFA, 1'b1, 32'd1,        1'b0},
        '{32'hFFFFFFFB, 32'hFFFFFFFF, 32'd1,        1'b1, 32'd4,        1'b0},
        '{32'hFFFFFFFB, 32'hA5A5A5A5, 32'h5A5A5A5A, 1'b0, 32'd0,        1'b0},
        // modulus two
        '{32'd2,        32'd3,        32'd7,        1'b1, 32'd1,        1'b0},
        '{32'd2,        32'hFFFFFFFE, 32'd9,        1'b1, 32'd0,        1'b0},
        // textbook rsa pair n = 61 * 53, e = 17, d = 2753
        '{32'd3233,     32'd65,       32'd17,       1'b1, 32'd2790,     1'b0},
        '{32'd3233,     32'd2790,     32'd2753,     1'b1, 32'd65,       1'b0},
        '{32'd3233,     32'd6023,     32'd2753,     1'b1, 32'd65,       1'b0},
        // power-of-two modulus
        '{32'h80000000, 32'd3,        32'h7FFFFFFF, 1'b0, 32'd0,        1'b0},
        '{32'h80000000, 32'hDEADBEEF, 32'h00012345, 1'b0, 32'd0,        1'b0},
        // modulus one written back explicitly
        '{32'd1,        32'h0F0F0F0F, 32'hF0F0F0F0, 1'b1, 32'd0,        1'b0}
    };

    modular_exponentiation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    // left-to-right square-and-multiply; every product is exact in 64 bits
    // before it is reduced, so nothing is truncated
    function automatic out_item_t predict_power(input logic [WORD_BITS-1:0] base,
                                                input logic [WORD_BITS-1:0] expo,
                                                input logic [WORD_BITS-1:0] modv);
        out_item_t       res;
        longint unsigned m;
        longint unsigned b;
        longint unsigned acc;
        int              i;
        res.power_result  = '0;
        res.modulus_error = 1'b0;
        if (expo == '0)
        begin
            res.power_result = 1;
            return res;
        end
        if (modv == '0)
        begin
            res.modulus_error = 1'b1;
            return res;
        end
        m   = 64'(modv);
        b   = 64'(base) % m;
        acc = 64'(1) % m;
        for (i = WORD_BITS - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % m;
            if (expo[i])
                acc = (acc * b) % m;
        end
        res.power_result = acc[WORD_BITS-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        $display("mismatch at %0t ns: %s, expected %h, got %h", $time, what, want, got);
        mismatch_count++;
    endtask

    // the modulus only changes with the block idle: input lowered and every
    // pending result collected first
    task automatic set_modulus(input logic [WORD_BITS-1:0] value);
        in_valid <= 1'b0;
        while (pending_powers.size() != 0)
            @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        modulus_now  = value;
    endtask

    // one input transfer, optionally after a burst of idle cycles; valid is
    // left high afterwards so back-to-back transfers need no extra edge
    task automatic push_operands(input logic [WORD_BITS-1:0] base,
                                 input logic [WORD_BITS-1:0] expo,
                                 input out_item_t want);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{base_value: base, exponent: expo};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_powers.push_back(want);
    endtask

    // receiver back-pressure in bursts, switched off for the last phase
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (idling_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 15);
        out_stall <= (stall_left > 0);
    end

    // output transfers checked field by field against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_powers.size() == 0)
                flag_mismatch("result with nothing pending", '0, 64'(out_data));
            else
            begin
                want = pending_powers.pop_front();
                if (out_data.power_result !== want.power_result)
                    flag_mismatch("power_result", 64'(want.power_result),
                                  64'(out_data.power_result));
                if (out_data.modulus_error !== want.modulus_error)
                    flag_mismatch("modulus_error", 64'(want.modulus_error),
                                  64'(out_data.modulus_error));
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        dir_row_t             row;
        out_item_t            want;
        logic [WORD_BITS-1:0] base;
        logic [WORD_BITS-1:0] expo;
        logic [WORD_BITS-1:0] modv;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, the modulus written whenever a row changes it
        for (int k = 0; k < DIRECTED_ROWS; k++)
        begin
            row = directed_rows[k];
            if (row.modulus != modulus_now)
                set_modulus(row.modulus);
            if (row.typed)
                want = '{power_result: row.power, modulus_error: row.err};
            else
                want = predict_power(row.base, row.expo, modulus_now);
            push_operands(row.base, row.expo, want);
        end

        // random phases, each under a new modulus; the last runs flat out
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            idling_on = (ph < RANDOM_PHASES - 1);
            case ($urandom_range(0, 9))
                0:       modv = '0;
                1:       modv = 1;
                2:       modv = ALL_ONES;
                3:       modv = $urandom_range(2, 1000);
                default: modv = $urandom;
            endcase
            set_modulus(modv);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                case ($urandom_range(0, 15))
                    0:       expo = '0;
                    1:       expo = ALL_ONES;
                    2:       expo = 1;
                    3:       expo = $urandom_range(1, 64);
                    4:       expo = 1 << $urandom_range(0, WORD_BITS - 1);
                    default: expo = $urandom;
                endcase
                case ($urandom_range(0, 7))
                    0:       base = '0;
                    1:       base = ALL_ONES;
                    2:       base = $urandom_range(0, 3);
                    default: base = $urandom;
                endcase
                push_operands(base, expo, predict_power(base, expo, modulus_now));
            end
        end

        // drain: all results in, then a short quiet spell for strays
        in_valid <= 1'b0;
        while (pending_powers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
hdl/mexp_pkg.sv
hdl/mexp_mulmod.sv
hdl/modular_exponentiation.sv
verif/tb_top.sv
